[rtl/keyed_pixel_compositor_defines.svh]
// Assertion macros shared by the keyed pixel compositor modules.
`ifndef KEYED_PIXEL_COMPOSITOR_DEFINES_SVH
`define KEYED_PIXEL_COMPOSITOR_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define KPC_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its cause.
`define KPC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A consequence that must hold in the cycle after its cause.
`define KPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/kpc_pkg.sv]
// Package with types, codes and constants of the keyed pixel compositor.
`timescale 1ns / 1ps
`default_nettype none
package kpc_pkg;

    // Default panel limits.
    localparam int DEF_MAX_PANEL_WIDTH  = 128;
    localparam int DEF_MAX_PANEL_HEIGHT = 64;

    // Pattern tile and palette geometry.
    localparam int PATTERN_SIZE = 16;
    localparam int PAT_AW       = $clog2(PATTERN_SIZE);
    localparam int PAT_CELLS    = PATTERN_SIZE * PATTERN_SIZE;
    localparam int PAT_ADDR_W   = $clog2(PAT_CELLS);
    localparam int PAL_ENTRIES  = 16;
    localparam int PAL_AW       = $clog2(PAL_ENTRIES);

    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = QUEUE_PTR_W + 1;

    // Field widths.
    localparam int COLOUR_W = 24;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 24;
    localparam int IN_DATA_W = 80;

    // Function codes of an input item.
    localparam logic [1:0] FUNC_COMPOSITE    = 2'd0;
    localparam logic [1:0] FUNC_LOAD_PATTERN = 2'd1;
    localparam logic [1:0] FUNC_LOAD_PALETTE = 2'd2;

    // Blend modes.
    localparam logic [1:0] BLEND_COPY    = 2'd0;
    localparam logic [1:0] BLEND_TINT    = 2'd1;
    localparam logic [1:0] BLEND_PALETTE = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_BLEND_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TINT_COLOUR    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_OFFSET = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PANEL_WIDTH    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PANEL_HEIGHT   = 3'd6;

    // Reset values of the size registers.
    localparam logic [7:0] RST_SOURCE_WIDTH  = 8'd64;
    localparam logic [6:0] RST_SOURCE_HEIGHT = 7'd32;
    localparam logic [7:0] RST_PANEL_WIDTH   = 8'd64;
    localparam logic [6:0] RST_PANEL_HEIGHT  = 7'd32;

    // Configuration registers as seen by the front and the back.
    typedef struct packed {
        logic [1:0]          blend_mode;
        logic [COLOUR_W-1:0] tint_colour;
        logic [PAL_AW-1:0]   pattern_offset;
        logic [7:0]          source_width;
        logic [6:0]          source_height;
        logic [7:0]          panel_width;
        logic [6:0]          panel_height;
    } t_cfg;

    // What the back has to do with an item.
    typedef enum logic [1:0] {
        KIND_PIXEL,
        KIND_LOAD_PAT,
        KIND_LOAD_PAL,
        KIND_NOP
    } t_kind;

    // A classified item as it travels through the queue.
    typedef struct packed {
        t_kind                 kind;
        logic [COLOUR_W-1:0]   src_rgb;
        logic [COLOUR_W-1:0]   dst_rgb;
        logic [7:0]            table_index;
        logic [COLOUR_W-1:0]   table_data;
        logic [PAT_ADDR_W-1:0] pat_addr;
        logic                  hit;
        logic                  frame_end;
    } t_item;

endpackage
`default_nettype wire

[rtl/kpc_front.sv]
// Front: accepts items, tracks the raster position and classifies each item.
`timescale 1ns / 1ps
`default_nettype none
`include "keyed_pixel_compositor_defines.svh"
module kpc_front #(
    parameter int MAX_PANEL_WIDTH  = kpc_pkg::DEF_MAX_PANEL_WIDTH,
    parameter int MAX_PANEL_HEIGHT = kpc_pkg::DEF_MAX_PANEL_HEIGHT
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  kpc_pkg::t_cfg                  i_cfg,
    input  wire                            i_valid,
    output logic                           o_ready,
    input  wire [1:0]                      i_func,
    input  wire [kpc_pkg::IN_DATA_W-1:0]   i_data,
    input  wire                            i_q_full,
    output logic                           o_push,
    output kpc_pkg::t_item                 o_item
);
    import kpc_pkg::*;

    localparam int CW     = (MAX_PANEL_WIDTH > 1) ? $clog2(MAX_PANEL_WIDTH) : 1;
    localparam int RW     = (MAX_PANEL_HEIGHT > 1) ? $clog2(MAX_PANEL_HEIGHT) : 1;
    localparam int CMPC_W = ((CW > 8) ? CW : 8) + 1;
    localparam int CMPR_W = ((RW > 7) ? RW : 7) + 1;
    localparam logic [CMPC_W-1:0] MAX_W = CMPC_W'(MAX_PANEL_WIDTH);
    localparam logic [CMPR_W-1:0] MAX_H = CMPR_W'(MAX_PANEL_HEIGHT);

    logic [CW-1:0]     r_col, n_col;
    logic [RW-1:0]     r_row, n_row;
    logic [CMPC_W-1:0] pw_ext, pw_eff, col_ext;
    logic [CMPR_W-1:0] ph_ext, ph_eff, row_ext;
    logic              col_wrap, row_wrap, in_source, src_nonzero, is_pixel;
    logic [COLOUR_W-1:0] src_rgb, dst_rgb;

    // Unpack the data word: source, destination, table index and table data.
    assign src_rgb = {i_data[7:0], i_data[15:8], i_data[23:16]};
    assign dst_rgb = {i_data[31:24], i_data[39:32], i_data[47:40]};

    // Effective panel size, saturated to one through the maximum.
    always_comb begin
        pw_ext = CMPC_W'(i_cfg.panel_width);
        ph_ext = CMPR_W'(i_cfg.panel_height);
        if (pw_ext == '0) begin
            pw_eff = CMPC_W'(1);
        end else if (pw_ext > MAX_W) begin
            pw_eff = MAX_W;
        end else begin
            pw_eff = pw_ext;
        end
        if (ph_ext == '0) begin
            ph_eff = CMPR_W'(1);
        end else if (ph_ext > MAX_H) begin
            ph_eff = MAX_H;
        end else begin
            ph_eff = ph_ext;
        end
    end

    // Position tests and the next raster position.
    always_comb begin
        col_ext   = CMPC_W'(r_col);
        row_ext   = CMPR_W'(r_row);
        col_wrap  = (col_ext + CMPC_W'(1)) >= pw_eff;
        row_wrap  = (row_ext + CMPR_W'(1)) >= ph_eff;
        in_source = (col_ext < CMPC_W'(i_cfg.source_width)) &&
                    (row_ext < CMPR_W'(i_cfg.source_height));
        n_col     = r_col;
        n_row     = r_row;
        if (col_wrap) begin
            n_col = '0;
            n_row = row_wrap ? '0 : r_row + RW'(1);
        end else begin
            n_col = r_col + CW'(1);
        end
    end

    assign o_ready     = !i_q_full;
    assign o_push      = i_valid && !i_q_full;
    assign is_pixel    = (i_func == FUNC_COMPOSITE);
    assign src_nonzero = (src_rgb != '0);

    // Classify the item for the back.
    always_comb begin
        o_item             = '0;
        o_item.src_rgb     = src_rgb;
        o_item.table_index = i_data[55:48];
        o_item.table_data  = i_data[79:56];
        o_item.pat_addr    = {PAT_AW'(r_row), PAT_AW'(r_col)};
        unique case (i_func)
            FUNC_COMPOSITE: begin
                o_item.kind      = KIND_PIXEL;
                o_item.dst_rgb   = dst_rgb;
                o_item.hit       = in_source && src_nonzero;
                o_item.frame_end = col_wrap && row_wrap;
            end
            FUNC_LOAD_PATTERN: begin
                o_item.kind = KIND_LOAD_PAT;
            end
            FUNC_LOAD_PALETTE: begin
                o_item.kind = (i_data[55:48] < 8'(PAL_ENTRIES)) ? KIND_LOAD_PAL : KIND_NOP;
            end
            default: begin
                o_item.kind = KIND_NOP;
            end
        endcase
    end

    // Raster counters move on composite items only.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (o_push && is_pixel) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    `KPC_ASSERT_NEXT(a_frame_end_wraps, o_push && o_item.frame_end, r_col == '0 && r_row == '0, "frame end without counter wrap")
    `KPC_ASSERT_IMP(a_load_no_frame_end, o_push && !is_pixel, !o_item.hit && !o_item.frame_end, "load item marked as pixel")
    `KPC_ASSERT_NEXT(a_load_keeps_pos, o_push && !is_pixel, $stable(r_col) && $stable(r_row), "load item moved the counters")

endmodule
`default_nettype wire

[rtl/kpc_queue.sv]
// Short queue of classified items between the front and the back.
`timescale 1ns / 1ps
`default_nettype none
`include "keyed_pixel_compositor_defines.svh"
module kpc_queue (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_push,
    input  kpc_pkg::t_item  i_item,
    output logic            o_full,
    input  wire             i_pop,
    output logic            o_valid,
    output kpc_pkg::t_item  o_item
);
    import kpc_pkg::*;

    t_item                  r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count;

    assign o_full  = (r_count == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    // Storage of the entries.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QUEUE_CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - QUEUE_CNT_W'(1);
            end
        end
    end

    `KPC_ASSERT_IMP(a_no_push_full, i_push, !o_full, "push into a full queue")
    `KPC_ASSERT_IMP(a_no_pop_empty, i_pop, o_valid, "pop from an empty queue")
    `KPC_ASSERT_ALWAYS(a_count_bound, r_count <= QUEUE_CNT_W'(QUEUE_DEPTH), "queue count overflow")

endmodule
`default_nettype wire

[rtl/kpc_back.sv]
// Back: applies table loads, looks up pattern and palette, and registers results.
`timescale 1ns / 1ps
`default_nettype none
`include "keyed_pixel_compositor_defines.svh"
module kpc_back (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  kpc_pkg::t_cfg                 i_cfg,
    input  wire                           i_q_valid,
    input  kpc_pkg::t_item                i_item,
    output logic                          o_pop,
    output logic                          o_valid,
    input  wire                           i_ready,
    output logic [kpc_pkg::COLOUR_W-1:0]  o_rgb,
    output logic                          o_replaced,
    output logic                          o_last
);
    import kpc_pkg::*;

    // Pattern memory with one valid bit per cell, and the palette.
    logic [PAL_AW-1:0]   r_pat_mem [PAT_CELLS];
    logic [PAT_CELLS-1:0] r_pat_vld;
    logic [COLOUR_W-1:0] r_palette [PAL_ENTRIES];

    // Lookup stage and output register.
    logic                r_s1_valid;
    t_item               r_s1;
    logic [PAL_AW-1:0]   r_cell;
    logic                r_cell_vld;
    logic                r_out_valid;
    logic [COLOUR_W-1:0] r_out_rgb;
    logic                r_out_replaced;
    logic                r_out_last;

    logic                out_en, s1_en;
    logic [PAL_AW-1:0]   cell_sel, pal_idx;
    logic [COLOUR_W-1:0] colour, n_rgb;
    logic                load_pat, load_pal;

    assign out_en   = !r_out_valid || i_ready;
    assign s1_en    = !r_s1_valid || out_en;
    assign o_pop    = i_q_valid && s1_en;
    assign load_pat = o_pop && (i_item.kind == KIND_LOAD_PAT);
    assign load_pal = o_pop && (i_item.kind == KIND_LOAD_PAL);

    // Pattern memory: written by loads, read for every item as it enters the lookup stage.
    always_ff @(posedge i_clk) begin
        if (load_pat) begin
            r_pat_mem[i_item.table_index] <= i_item.table_data[PAL_AW-1:0];
        end
        if (o_pop) begin
            r_cell <= r_pat_mem[i_item.pat_addr];
        end
    end

    // Cell valid bits; a cell never written reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_vld  <= '0;
            r_cell_vld <= 1'b0;
        end else begin
            if (load_pat) begin
                r_pat_vld[i_item.table_index] <= 1'b1;
            end
            if (o_pop) begin
                r_cell_vld <= r_pat_vld[i_item.pat_addr];
            end
        end
    end

    // Palette registers, cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PAL_ENTRIES; i++) begin
                r_palette[i] <= '0;
            end
        end else if (load_pal) begin
            r_palette[i_item.table_index[PAL_AW-1:0]] <= i_item.table_data;
        end
    end

    // Replacement colour for the item in the lookup stage.
    always_comb begin
        cell_sel = r_cell_vld ? r_cell : '0;
        pal_idx  = cell_sel + i_cfg.pattern_offset;
        case (i_cfg.blend_mode)
            BLEND_TINT:    colour = i_cfg.tint_colour;
            BLEND_PALETTE: colour = r_palette[pal_idx];
            default:       colour = r_s1.src_rgb;
        endcase
        n_rgb = r_s1.hit ? colour : r_s1.dst_rgb;
    end

    // Lookup stage control and payload.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_en) begin
            r_s1_valid <= i_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1 <= i_item;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_en) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_en && r_s1_valid) begin
            r_out_rgb      <= n_rgb;
            r_out_replaced <= r_s1.hit;
            r_out_last     <= r_s1.frame_end;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_rgb      = r_out_rgb;
    assign o_replaced = r_out_replaced;
    assign o_last     = r_out_last;

    `KPC_ASSERT_NEXT(a_load_result_zero, out_en && r_s1_valid && r_s1.kind != KIND_PIXEL, r_out_rgb == '0 && !r_out_replaced && !r_out_last, "load item gave a nonzero result")
    `KPC_ASSERT_NEXT(a_out_holds_stall, r_out_valid && !i_ready, r_out_valid && $stable(r_out_rgb), "stalled result changed")
    `KPC_ASSERT_IMP(a_pop_needs_room, o_pop, !r_s1_valid || out_en, "lookup stage overwritten")

endmodule
`default_nettype wire

[rtl/keyed_pixel_compositor.sv]
// Keyed pixel compositor: an accepted item passes through the queue, the registered pattern memory
// read of the lookup stage and the output register. Throughput is one item per cycle while the
// output is not stalled; the front, the four-entry queue and the back each stall alone.
// Reset is synchronous and active low: it clears counters, queue, cell valid bits and palette,
// and loads the configuration registers with their default values; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module keyed_pixel_compositor #(
    parameter int MAX_PANEL_WIDTH  = kpc_pkg::DEF_MAX_PANEL_WIDTH,
    parameter int MAX_PANEL_HEIGHT = kpc_pkg::DEF_MAX_PANEL_HEIGHT
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // Configuration write port.
    input  wire                              i_cfg_we,
    input  wire [kpc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire [kpc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // Input items.
    input  wire                              s_axis_tvalid,
    output logic                             s_axis_tready,
    // tdata: src_red, src_green, src_blue, dst_red, dst_green, dst_blue,
    //        table_index [55:48], table_data [79:56]
    input  wire [kpc_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // tuser: func
    input  wire [1:0]                        s_axis_tuser,
    // Result items.
    output logic                             m_axis_tvalid,
    input  wire                              m_axis_tready,
    // tdata: out_red [7:0], out_green [15:8], out_blue [23:16]
    output logic [kpc_pkg::COLOUR_W-1:0]     m_axis_tdata,
    // tuser: replaced
    output logic                             m_axis_tuser,
    // tlast: frame_end
    output logic                             m_axis_tlast
);
    import kpc_pkg::*;

    t_cfg                r_cfg;
    logic                q_full, q_push, q_valid, q_pop;
    t_item               f_item, q_item;
    logic [COLOUR_W-1:0] b_rgb;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.blend_mode     <= BLEND_COPY;
            r_cfg.tint_colour    <= '0;
            r_cfg.pattern_offset <= '0;
            r_cfg.source_width   <= RST_SOURCE_WIDTH;
            r_cfg.source_height  <= RST_SOURCE_HEIGHT;
            r_cfg.panel_width    <= RST_PANEL_WIDTH;
            r_cfg.panel_height   <= RST_PANEL_HEIGHT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_BLEND_MODE:     r_cfg.blend_mode     <= i_cfg_data[1:0];
                CFG_TINT_COLOUR:    r_cfg.tint_colour    <= i_cfg_data;
                CFG_PATTERN_OFFSET: r_cfg.pattern_offset <= i_cfg_data[PAL_AW-1:0];
                CFG_SOURCE_WIDTH:   r_cfg.source_width   <= i_cfg_data[7:0];
                CFG_SOURCE_HEIGHT:  r_cfg.source_height  <= i_cfg_data[6:0];
                CFG_PANEL_WIDTH:    r_cfg.panel_width    <= i_cfg_data[7:0];
                CFG_PANEL_HEIGHT:   r_cfg.panel_height   <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // Front part: accept and classify.
    kpc_front #(
        .MAX_PANEL_WIDTH  (MAX_PANEL_WIDTH),
        .MAX_PANEL_HEIGHT (MAX_PANEL_HEIGHT)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_func   (s_axis_tuser),
        .i_data   (s_axis_tdata),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_item   (f_item)
    );

    // Queue between the two parts.
    kpc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (f_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    // Back part: tables, lookup and output register.
    kpc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_q_valid  (q_valid),
        .i_item     (q_item),
        .o_pop      (q_pop),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_rgb      (b_rgb),
        .o_replaced (m_axis_tuser),
        .o_last     (m_axis_tlast)
    );

    // Colour word is 0xRRGGBB; the stream carries red in the lowest byte.
    assign m_axis_tdata = {b_rgb[7:0], b_rgb[15:8], b_rgb[23:16]};

endmodule
`default_nettype wire

[sim/testbench.sv]
// Self-checking testbench for the keyed pixel compositor stream block.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
    import kpc_pkg::*;

    // Function code that the block must ignore.
    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    // Blend mode code that falls back to a plain copy.
    localparam logic [1:0] BLEND_UNUSED = 2'd3;

    // One result item as the block presents it.
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       replaced;
        logic       frame_end;
    } t_pixel_out;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [1:0]            s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [COLOUR_W-1:0]   m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  m_axis_tlast;

    keyed_pixel_compositor u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the configuration registers.
    logic [1:0]  mode_shadow;
    logic [23:0] tint_shadow;
    logic [3:0]  offset_shadow;
    logic [7:0]  src_width_shadow;
    logic [6:0]  src_height_shadow;
    logic [7:0]  panel_width_shadow;
    logic [6:0]  panel_height_shadow;

    // Shadow copy of the raster position and the lookup tables.
    int unsigned column_pos;
    int unsigned row_pos;
    logic [3:0]  pattern_shadow [PAT_CELLS];
    logic [23:0] palette_shadow [PAL_ENTRIES];

    t_pixel_out  expected_pixels [$];
    int          mismatch_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_cycles_left = 0;

    // Packs the input fields into tdata, red first in the lowest byte.
    function automatic logic [IN_DATA_W-1:0] make_payload(input logic [23:0] src_rgb,
            input logic [23:0] dst_rgb, input logic [7:0] index, input logic [23:0] data);
        return {data, index, dst_rgb[7:0], dst_rgb[15:8], dst_rgb[23:16],
                src_rgb[7:0], src_rgb[15:8], src_rgb[23:16]};
    endfunction

    // Works out the result of one item and advances the shadow state.
    function automatic t_pixel_out predict_pixel(input logic [1:0] func,
            input logic [IN_DATA_W-1:0] d);
        int unsigned eff_width;
        int unsigned eff_height;
        logic [23:0] colour;
        logic [3:0]  cell_val;
        logic [3:0]  entry;
        t_pixel_out  res;
        res = '0;
        case (func)
            FUNC_LOAD_PATTERN: begin
                pattern_shadow[d[55:48]] = d[59:56];
            end
            FUNC_LOAD_PALETTE: begin
                if (d[55:48] < 8'(PAL_ENTRIES)) palette_shadow[d[51:48]] = d[79:56];
            end
            FUNC_COMPOSITE: begin
                eff_width = (panel_width_shadow == 0) ? 1 :
                    (panel_width_shadow > DEF_MAX_PANEL_WIDTH) ? DEF_MAX_PANEL_WIDTH :
                    int'(panel_width_shadow);
                eff_height = (panel_height_shadow == 0) ? 1 :
                    (panel_height_shadow > DEF_MAX_PANEL_HEIGHT) ? DEF_MAX_PANEL_HEIGHT :
                    int'(panel_height_shadow);
                res.red   = d[31:24];
                res.green = d[39:32];
                res.blue  = d[47:40];
                // A non-black source pixel inside the source area is keyed in.
                if (column_pos < 32'(src_width_shadow) && row_pos < 32'(src_height_shadow) &&
                        d[23:0] != 24'h0) begin
                    case (mode_shadow)
                        BLEND_TINT: begin
                            colour = tint_shadow;
                        end
                        BLEND_PALETTE: begin
                            cell_val = pattern_shadow[{row_pos[3:0], column_pos[3:0]}];
                            entry    = offset_shadow + cell_val;
                            colour   = palette_shadow[entry];
                        end
                        default: begin
                            colour = {d[7:0], d[15:8], d[23:16]};
                        end
                    endcase
                    res.replaced = 1'b1;
                    res.red      = colour[23:16];
                    res.green    = colour[15:8];
                    res.blue     = colour[7:0];
                end
                // Raster advance; a counter past a shrunken panel wraps at once.
                if (column_pos + 1 >= eff_width) begin
                    column_pos = 0;
                    if (row_pos + 1 >= eff_height) begin
                        row_pos = 0;
                        res.frame_end = 1'b1;
                    end else begin
                        row_pos++;
                    end
                end else begin
                    column_pos++;
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    // Hold-off counter for the long output stall.
    always @(posedge i_clk) begin
        if (hold_cycles_left != 0) begin
            hold_cycles_left <= hold_cycles_left - 1;
        end
    end

    // Output side readiness, stalled at random or held off.
    always @(posedge i_clk) begin
        m_axis_tready <= (hold_cycles_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end

    // Compares every result item with the oldest expectation.
    always @(posedge i_clk) begin : check_results
        t_pixel_out got;
        t_pixel_out want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tdata[23:16],
                   m_axis_tuser, m_axis_tlast};
            if (expected_pixels.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected result: rgb %h %h %h replaced %b frame_end %b",
                             got.red, got.green, got.blue, got.replaced, got.frame_end);
                end
            end else begin
                want = expected_pixels.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("mismatch: expected rgb %h %h %h replaced %b frame_end %b",
                                 want.red, want.green, want.blue, want.replaced,
                                 want.frame_end);
                        $display("          actual   rgb %h %h %h replaced %b frame_end %b",
                                 got.red, got.green, got.blue, got.replaced, got.frame_end);
                    end
                end
            end
        end
    end

    // Offers one item, waits for it to be taken and records its expectation.
    task automatic send_item(input logic [1:0] func, input logic [IN_DATA_W-1:0] payload);
        t_pixel_out want;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= payload;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        want = predict_pixel(func, payload);
        expected_pixels.push_back(want);
    endtask

    // Sends one item with a random function and random content.
    task automatic send_random_item();
        int unsigned pick;
        logic [1:0]  func;
        logic [23:0] src_rgb;
        logic [7:0]  index;
        pick = $urandom_range(99);
        if (pick < 78) func = FUNC_COMPOSITE;
        else if (pick < 87) func = FUNC_LOAD_PATTERN;
        else if (pick < 96) func = FUNC_LOAD_PALETTE;
        else func = FUNC_UNUSED;
        case ($urandom_range(7))
            0, 1:    src_rgb = 24'h0;
            2:       src_rgb = 24'h1 << $urandom_range(23);
            default: src_rgb = 24'($urandom);
        endcase
        if (func == FUNC_LOAD_PALETTE && $urandom_range(3) != 0) begin
            index = 8'($urandom_range(15));
        end else begin
            index = 8'($urandom_range(255));
        end
        send_item(func, make_payload(src_rgb, 24'($urandom), index, 24'($urandom)));
    endtask

    // Stops offering items and waits until every result has come back.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Puts one register write on the port; the caller lowers the enable.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [23:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
    endtask

    // Writes all seven registers; only called while the block is idle.
    task automatic apply_settings(input logic [1:0] mode, input logic [23:0] tint,
            input logic [3:0] offset, input logic [7:0] src_w, input logic [6:0] src_h,
            input logic [7:0] pan_w, input logic [6:0] pan_h);
        write_reg(CFG_BLEND_MODE, 24'(mode));
        write_reg(CFG_TINT_COLOUR, tint);
        write_reg(CFG_PATTERN_OFFSET, 24'(offset));
        write_reg(CFG_SOURCE_WIDTH, 24'(src_w));
        write_reg(CFG_SOURCE_HEIGHT, 24'(src_h));
        write_reg(CFG_PANEL_WIDTH, 24'(pan_w));
        write_reg(CFG_PANEL_HEIGHT, 24'(pan_h));
        i_cfg_we            <= 1'b0;
        mode_shadow         = mode;
        tint_shadow         = tint;
        offset_shadow       = offset;
        src_width_shadow    = src_w;
        src_height_shadow   = src_h;
        panel_width_shadow  = pan_w;
        panel_height_shadow = pan_h;
    endtask

    // Picks a panel dimension: mostly tiny so that frames end often.
    function automatic int unsigned pick_panel_size(input int unsigned max_size,
            input int unsigned reg_max);
        case ($urandom_range(9))
            0:       return 0;
            1:       return max_size;
            2:       return reg_max;
            3:       return $urandom_range(reg_max);
            default: return $urandom_range(1, 6);
        endcase
    endfunction

    // Chooses a fresh random configuration and writes it.
    task automatic randomize_settings();
        logic [7:0] src_w;
        logic [6:0] src_h;
        src_w = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(8));
        src_h = ($urandom_range(3) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(6));
        apply_settings(2'($urandom_range(3)), 24'($urandom), 4'($urandom), src_w, src_h,
                       8'(pick_panel_size(DEF_MAX_PANEL_WIDTH, 255)),
                       7'(pick_panel_size(DEF_MAX_PANEL_HEIGHT, 127)));
    endtask

    // Palette and pattern loads at the edges of their index and data ranges.
    task automatic test_table_loads();
        send_item(FUNC_LOAD_PALETTE, make_payload(24'h0, 24'h0, 8'd0, 24'hFFFFFF));
        send_item(FUNC_LOAD_PALETTE, make_payload(24'h0, 24'h0, 8'd15, 24'h800001));
        // Palette entries past the end are dropped.
        send_item(FUNC_LOAD_PALETTE, make_payload(24'h0, 24'h0, 8'd16, 24'hABCDEF));
        send_item(FUNC_LOAD_PALETTE, make_payload(24'h0, 24'h0, 8'd255, 24'hFFFFFF));
        send_item(FUNC_LOAD_PATTERN, make_payload(24'h0, 24'h0, 8'd0, 24'hFFFFFF));
        send_item(FUNC_LOAD_PATTERN, make_payload(24'h0, 24'h0, 8'd255, 24'h00000A));
        send_item(FUNC_LOAD_PATTERN, make_payload(24'h0, 24'h0, 8'd1, 24'hFFFFF0));
        // The unused function code must leave everything untouched.
        send_item(FUNC_UNUSED, make_payload(24'hFFFFFF, 24'hFFFFFF, 8'hFF, 24'hFFFFFF));
    endtask

    // Colour keying in copy mode with the reset configuration.
    task automatic test_copy_keying();
        send_item(FUNC_COMPOSITE, make_payload(24'h000000, 24'hFFFFFF, 8'h0, 24'h0));
        send_item(FUNC_COMPOSITE, make_payload(24'hFFFFFF, 24'h000000, 8'h0, 24'h0));
        send_item(FUNC_COMPOSITE, make_payload(24'h000001, 24'h123456, 8'h0, 24'h0));
        send_item(FUNC_COMPOSITE, make_payload(24'h800000, 24'h00FF00, 8'h0, 24'h0));
        drain_results();
    endtask

    // Tint, palette and the unused blend mode, with size extremes.
    task automatic test_blend_modes();
        // Panel shrinks below the current column, so the counters wrap.
        apply_settings(BLEND_TINT, 24'hFFFFFF, 4'd0, 8'd255, 7'd127, 8'd2, 7'd2);
        send_item(FUNC_COMPOSITE, make_payload(24'h010203, 24'h000000, 8'h0, 24'h0));
        send_item(FUNC_COMPOSITE, make_payload(24'h000000, 24'hA5A5A5, 8'h0, 24'h0));
        drain_results();
        // Empty source: nothing is ever replaced.
        apply_settings(BLEND_PALETTE, 24'h0, 4'd15, 8'd0, 7'd0, 8'd3, 7'd1);
        send_item(FUNC_COMPOSITE, make_payload(24'hFFFFFF, 24'h5A5A5A, 8'h0, 24'h0));
        drain_results();
        // Zero panel size saturates to one pixel: every item ends a frame.
        apply_settings(BLEND_PALETTE, 24'h0, 4'd1, 8'd128, 7'd64, 8'd0, 7'd0);
        send_item(FUNC_COMPOSITE, make_payload(24'hFFFFFF, 24'h000000, 8'h0, 24'h0));
        send_item(FUNC_COMPOSITE, make_payload(24'h00FF00, 24'hFFFFFF, 8'h0, 24'h0));
        drain_results();
        // Oversized panel saturates to the maximum.
        apply_settings(BLEND_UNUSED, 24'h0, 4'd0, 8'd128, 7'd64, 8'd255, 7'd127);
        send_item(FUNC_COMPOSITE, make_payload(24'h0000FF, 24'h000000, 8'h0, 24'h0));
        send_item(FUNC_COMPOSITE, make_payload(24'hFF0000, 24'hFFFFFF, 8'h0, 24'h0));
        drain_results();
    endtask

    // Random traffic under one idling pattern, reconfigured every few dozen items.
    task automatic test_random_traffic(input int count, input int idle_pct,
            input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct <= stall_pct;
        for (int sent = 0; sent < count; sent += 48) begin
            randomize_settings();
            for (int k = 0; k < 48; k++) send_random_item();
            drain_results();
        end
    endtask

    // Output held off for a long stretch while items keep coming.
    task automatic test_output_backpressure();
        send_idle_pct    = 0;
        recv_stall_pct   <= 0;
        hold_cycles_left <= 300;
        apply_settings(BLEND_PALETTE, 24'h00FF00, 4'd7, 8'd4, 7'd3, 8'd5, 7'd4);
        for (int k = 0; k < 60; k++) send_random_item();
        drain_results();
    endtask

    // Run limit.
    initial begin
        #2_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    initial begin
        mode_shadow         = BLEND_COPY;
        tint_shadow         = '0;
        offset_shadow       = '0;
        src_width_shadow    = RST_SOURCE_WIDTH;
        src_height_shadow   = RST_SOURCE_HEIGHT;
        panel_width_shadow  = RST_PANEL_WIDTH;
        panel_height_shadow = RST_PANEL_HEIGHT;
        column_pos          = 0;
        row_pos             = 0;
        foreach (pattern_shadow[k]) pattern_shadow[k] = '0;
        foreach (palette_shadow[k]) palette_shadow[k] = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_table_loads();
        test_copy_keying();
        test_blend_modes();
        test_random_traffic(240, 0, 0);
        test_random_traffic(240, 57, 0);
        test_random_traffic(240, 0, 57);
        test_random_traffic(240, 24, 24);
        test_output_backpressure();

        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && expected_pixels.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire

[sim.f]
+incdir+rtl
rtl/kpc_pkg.sv
rtl/kpc_front.sv
rtl/kpc_queue.sv
rtl/kpc_back.sv
rtl/keyed_pixel_compositor.sv
sim/testbench.sv
